### design/fvac_pkg.sv
// ----------------------------------------------------------------------------
// fvac_pkg: shared types and constants for the frame voice activity capture
// Payload structs, configuration record, capture action codes and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fvac_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int RUN_W    = 16;
    localparam int MS_W     = 16;
    localparam int DUR_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Frame extremes restored after each frame
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENT_TO_STOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TO_START   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PUBLISH_MIN_MS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_DURATION_MS = 3'd4;

    // Register reset values
    localparam logic [15:0]      RST_LEVEL_THRESH      = 16'd1000;
    localparam logic [15:0]      RST_SILENT_TO_STOP    = 16'd200;
    localparam logic [15:0]      RST_ACTIVE_TO_START   = 16'd1;
    localparam logic [15:0]      RST_PUBLISH_MIN_MS    = 16'd500;
    localparam logic [DUR_W-1:0] RST_FRAME_DURATION_MS = 10'd20;

    // Capture action reported per frame
    typedef enum logic [2:0] {
        ACT_DROP         = 3'd0,
        ACT_START        = 3'd1,
        ACT_RECORD       = 3'd2,
        ACT_STOP_DISCARD = 3'd3,
        ACT_STOP_PUBLISH = 3'd4
    } t_action;

    // Capture state, one-hot
    typedef enum logic [1:0] {
        CAP_IDLE = 2'b01,
        CAP_REC  = 2'b10
    } t_cap_state;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_end;
    } t_in_item;

    typedef struct packed {
        t_action      frame_action;
        logic [15:0]  peak_to_peak;
        logic         frame_silent;
    } t_out_item;

    typedef struct packed {
        logic [15:0]      level_thresh;
        logic [RUN_W-1:0] silent_frames_to_stop;
        logic [RUN_W-1:0] active_frames_to_start;
        logic [MS_W-1:0]  publish_min_ms;
        logic [DUR_W-1:0] frame_duration_ms;
    } t_cfg;

    // Finished frame handed from the tracker to the decision stage
    typedef struct packed {
        logic        valid;
        logic [15:0] peak_to_peak;
    } t_frame_info;

    // Saturating 16-bit increment
    function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] a);
        sat_inc = (a == {RUN_W{1'b1}}) ? a : a + 1'b1;
    endfunction

    // Saturating 16-bit add of a frame duration
    function automatic logic [MS_W-1:0] sat_add_ms(input logic [MS_W-1:0] a,
                                                   input logic [DUR_W-1:0] b);
        logic [MS_W:0] sum;
        sum = {1'b0, a} + {{(MS_W + 1 - DUR_W){1'b0}}, b};
        sat_add_ms = sum[MS_W] ? {MS_W{1'b1}} : sum[MS_W-1:0];
    endfunction

endpackage

`default_nettype wire

### design/fvac_cfg_regs.sv
// ----------------------------------------------------------------------------
// fvac_cfg_regs: configuration register file
// Five registers written by index; unknown indexes are ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fvac_cfg_regs
    import fvac_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    // Register writes, low bits kept per register width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level_thresh           <= RST_LEVEL_THRESH;
            r_cfg.silent_frames_to_stop  <= RST_SILENT_TO_STOP;
            r_cfg.active_frames_to_start <= RST_ACTIVE_TO_START;
            r_cfg.publish_min_ms         <= RST_PUBLISH_MIN_MS;
            r_cfg.frame_duration_ms      <= RST_FRAME_DURATION_MS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LEVEL_THRESH:      r_cfg.level_thresh           <= i_cfg_data;
                CFG_SILENT_TO_STOP:    r_cfg.silent_frames_to_stop  <= i_cfg_data;
                CFG_ACTIVE_TO_START:   r_cfg.active_frames_to_start <= i_cfg_data;
                CFG_PUBLISH_MIN_MS:    r_cfg.publish_min_ms         <= i_cfg_data;
                CFG_FRAME_DURATION_MS: r_cfg.frame_duration_ms      <= i_cfg_data[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### design/fvac_minmax.sv
// ----------------------------------------------------------------------------
// fvac_minmax: input register and per-frame min/max tracker
// Registers each sample, folds it into the running extremes and emits the
// peak-to-peak value on the last sample of a frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fvac_minmax
    import fvac_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  t_in_item      i_in_item,
    input  wire logic     i_out_free,
    output t_frame_info   o_frame
);

    logic                       r_s1_valid;
    t_in_item                   r_s1;
    logic signed [SAMPLE_W-1:0] r_min;
    logic signed [SAMPLE_W-1:0] r_max;
    logic signed [SAMPLE_W-1:0] n_min;
    logic signed [SAMPLE_W-1:0] n_max;
    logic [SAMPLE_W:0]          diff;
    logic                       s1_go;
    logic                       in_accept;

    // A frame-end sample waits for a free result slot; others always move on
    assign s1_go      = r_s1_valid && (!r_s1.frame_end || i_out_free);
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_accept  = i_in_valid && o_in_ready;

    // Extremes including the registered sample
    always_comb begin
        n_min = (r_s1.sample < r_min) ? r_s1.sample : r_min;
        n_max = (r_s1.sample > r_max) ? r_s1.sample : r_max;
        diff  = {n_max[SAMPLE_W-1], n_max} - {n_min[SAMPLE_W-1], n_min};
    end

    assign o_frame.valid        = s1_go && r_s1.frame_end;
    assign o_frame.peak_to_peak = diff[SAMPLE_W-1:0];

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept || (r_s1_valid && !s1_go);
        end
        if (in_accept) begin
            r_s1 <= i_in_item;
        end
    end

    // Running extremes, restored at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= SAMPLE_MAX;
            r_max <= SAMPLE_MIN;
        end else if (s1_go) begin
            if (r_s1.frame_end) begin
                r_min <= SAMPLE_MAX;
                r_max <= SAMPLE_MIN;
            end else begin
                r_min <= n_min;
                r_max <= n_max;
            end
        end
    end

endmodule

`default_nettype wire

### design/fvac_decide.sv
// ----------------------------------------------------------------------------
// fvac_decide: frame classification, capture control and result register
// Updates run counters and recorded time per frame and holds the result
// until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fvac_decide
    import fvac_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  t_cfg        i_cfg,
    input  t_frame_info i_frame,
    output logic        o_out_free,
    output logic        o_out_valid,
    input  wire logic   i_out_ready,
    output t_out_item   o_out_item
);

    logic             r_out_valid;
    t_out_item        r_out;
    t_cap_state       r_state;
    t_cap_state       n_state;
    logic [RUN_W-1:0] r_silent_run;
    logic [RUN_W-1:0] r_active_run;
    logic [RUN_W-1:0] n_silent_run;
    logic [RUN_W-1:0] n_active_run;
    logic [MS_W-1:0]  r_recorded_ms;
    logic [MS_W-1:0]  n_recorded_ms;
    logic             silent;
    t_action          action;

    assign o_out_free = !r_out_valid || i_out_ready;

    // Classification and run counters
    always_comb begin
        silent = i_frame.peak_to_peak < i_cfg.level_thresh;
        if (silent) begin
            n_silent_run = sat_inc(r_silent_run);
            n_active_run = '0;
        end else begin
            n_silent_run = '0;
            n_active_run = sat_inc(r_active_run);
        end
    end

    // Capture decision
    always_comb begin
        n_state       = r_state;
        n_recorded_ms = r_recorded_ms;
        action        = ACT_DROP;
        case (r_state)
            CAP_IDLE: begin
                if (n_active_run >= i_cfg.active_frames_to_start) begin
                    action        = ACT_START;
                    n_state       = CAP_REC;
                    n_recorded_ms = {{(MS_W - DUR_W){1'b0}}, i_cfg.frame_duration_ms};
                end
            end
            CAP_REC: begin
                if (n_silent_run >= i_cfg.silent_frames_to_stop) begin
                    action        = (r_recorded_ms > i_cfg.publish_min_ms) ?
                                    ACT_STOP_PUBLISH : ACT_STOP_DISCARD;
                    n_state       = CAP_IDLE;
                    n_recorded_ms = '0;
                end else begin
                    action        = ACT_RECORD;
                    n_recorded_ms = sat_add_ms(r_recorded_ms, i_cfg.frame_duration_ms);
                end
            end
            default: begin
                n_state = CAP_IDLE;
            end
        endcase
    end

    // Frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= CAP_IDLE;
            r_silent_run  <= '0;
            r_active_run  <= '0;
            r_recorded_ms <= '0;
        end else if (i_frame.valid) begin
            r_state       <= n_state;
            r_silent_run  <= n_silent_run;
            r_active_run  <= n_active_run;
            r_recorded_ms <= n_recorded_ms;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_frame.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_frame.valid) begin
            r_out.frame_action <= action;
            r_out.peak_to_peak <= i_frame.peak_to_peak;
            r_out.frame_silent <= silent;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

### design/frame_voice_activity_capture.sv
// A frame-end sample's result passes the input register, then the result
// register, and becomes valid there; other samples give none.
// Throughput: one sample per cycle; a frame-end sample stalls only while
// the result register still holds an untaken result.
// Reset (synchronous, active low) clears counters, capture state, extremes
// and the registers to their defaults; the configuration port is always ready.
`timescale 1ns / 1ps
`default_nettype none

module frame_voice_activity_capture
    import fvac_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // sample stream
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  t_in_item                   i_in_item,
    // frame results
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_item,
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg        cfg;
    t_frame_info frame;
    logic        out_free;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    fvac_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Sample register and frame extremes
    fvac_minmax u_minmax (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_out_free (out_free),
        .o_frame    (frame)
    );

    // Capture control and result register
    fvac_decide u_decide (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_frame     (frame),
        .o_out_free  (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

### design/fvac_checker.sv
// ----------------------------------------------------------------------------
// fvac_checker: port-level checks for the frame voice activity capture
// Watches handshakes and the sequence of capture actions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fvac_checker
    import fvac_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item
);

    logic r_seen_cap;
    logic out_xact;
    logic act_in_cap;

    assign out_xact   = o_out_valid && i_out_ready;
    assign act_in_cap = (o_out_item.frame_action == ACT_RECORD) ||
                        (o_out_item.frame_action == ACT_STOP_DISCARD) ||
                        (o_out_item.frame_action == ACT_STOP_PUBLISH);

    // Capture state as implied by the delivered actions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_cap <= 1'b0;
        end else if (out_xact) begin
            if (o_out_item.frame_action == ACT_START) begin
                r_seen_cap <= 1'b1;
            end else if (o_out_item.frame_action == ACT_STOP_DISCARD ||
                         o_out_item.frame_action == ACT_STOP_PUBLISH) begin
                r_seen_cap <= 1'b0;
            end
        end
    end

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Record and stop only inside a capture; drop and start only outside
    a_action_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xact |-> (act_in_cap == r_seen_cap))
        else $error("capture action out of sequence");

    // Empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

endmodule

bind frame_voice_activity_capture fvac_checker u_fvac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire

### verif/fvac_frame_checker.sv
// ----------------------------------------------------------------------------
// fvac_frame_checker: frame result predictor and comparator
// Follows the sample, result and register write channels of the voice
// activity capture. It keeps its own copy of the frame extremes, run counters
// and capture state, and queues the result due for each frame-end sample.
// Each result transaction is checked field by field against the oldest entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fvac_frame_checker
    import fvac_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample channel
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_item,
    // result channel
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_item,
    // register writes
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // status for the testbench top
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_frames_checked,
    output logic [4:0]            o_actions_seen
);

    t_cfg               regs;
    logic signed [15:0] frame_lo;
    logic signed [15:0] frame_hi;
    logic [15:0]        quiet_run;
    logic [15:0]        loud_run;
    logic               recording;
    logic [15:0]        rec_ms;
    t_out_item          expected_frames [$];
    int                 fail_total    = 0;
    int                 checked_total = 0;
    logic [4:0]         seen          = '0;

    assign o_fail_count     = fail_total;
    assign o_frames_checked = checked_total;
    assign o_actions_seen   = seen;

    // 16-bit add that sticks at all ones
    function automatic logic [15:0] add_clamped16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[16] ? 16'hFFFF : sum[15:0];
    endfunction

    // Fold one sample into the frame; on frame end decide the capture action
    task automatic track_sample(input t_in_item item);
        t_out_item   res;
        logic [15:0] span;
        logic        quiet;
        if ($signed(item.sample) < frame_lo) frame_lo = item.sample;
        if ($signed(item.sample) > frame_hi) frame_hi = item.sample;
        if (item.frame_end) begin
            span     = frame_hi - frame_lo;
            frame_lo = SAMPLE_MAX;
            frame_hi = SAMPLE_MIN;
            quiet    = span < regs.level_thresh;
            if (quiet) begin
                quiet_run = add_clamped16(quiet_run, 16'd1);
                loud_run  = '0;
            end else begin
                loud_run  = add_clamped16(loud_run, 16'd1);
                quiet_run = '0;
            end

            if (recording && quiet_run >= regs.silent_frames_to_stop) begin
                res.frame_action = (rec_ms > regs.publish_min_ms) ? ACT_STOP_PUBLISH
                                                                  : ACT_STOP_DISCARD;
                recording = 1'b0;
                rec_ms    = '0;
            end else if (!recording) begin
                if (loud_run >= regs.active_frames_to_start) begin
                    res.frame_action = ACT_START;
                    recording        = 1'b1;
                    rec_ms           = 16'(regs.frame_duration_ms);
                end else begin
                    res.frame_action = ACT_DROP;
                end
            end else begin
                res.frame_action = ACT_RECORD;
                rec_ms = add_clamped16(rec_ms, 16'(regs.frame_duration_ms));
            end

            res.peak_to_peak = span;
            res.frame_silent = quiet;
            expected_frames.push_back(res);
        end
    endtask

    // Channel monitor: compare results, then apply writes and new samples
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            regs.level_thresh           = RST_LEVEL_THRESH;
            regs.silent_frames_to_stop  = RST_SILENT_TO_STOP;
            regs.active_frames_to_start = RST_ACTIVE_TO_START;
            regs.publish_min_ms         = RST_PUBLISH_MIN_MS;
            regs.frame_duration_ms      = RST_FRAME_DURATION_MS;
            frame_lo  = SAMPLE_MAX;
            frame_hi  = SAMPLE_MIN;
            quiet_run = '0;
            loud_run  = '0;
            recording = 1'b0;
            rec_ms    = '0;
            expected_frames.delete();
        end else begin
            // result transaction
            if (i_out_valid && i_out_ready) begin
                if (expected_frames.size() == 0) begin
                    $error("unexpected result: action %0d, peak_to_peak %0d, silent %0d",
                           i_out_item.frame_action, i_out_item.peak_to_peak,
                           i_out_item.frame_silent);
                    fail_total++;
                end else begin
                    want = expected_frames.pop_front();
                    if (i_out_item.frame_action !== want.frame_action) begin
                        $error("frame_action mismatch: expected %0d, got %0d",
                               want.frame_action, i_out_item.frame_action);
                        fail_total++;
                    end
                    if (i_out_item.peak_to_peak !== want.peak_to_peak) begin
                        $error("peak_to_peak mismatch: expected %0d, got %0d",
                               want.peak_to_peak, i_out_item.peak_to_peak);
                        fail_total++;
                    end
                    if (i_out_item.frame_silent !== want.frame_silent) begin
                        $error("frame_silent mismatch: expected %0d, got %0d",
                               want.frame_silent, i_out_item.frame_silent);
                        fail_total++;
                    end
                    seen[int'(want.frame_action)] = 1'b1;
                    checked_total++;
                end
            end

            // register write transaction; unknown indexes are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LEVEL_THRESH:      regs.level_thresh           = i_cfg_data;
                    CFG_SILENT_TO_STOP:    regs.silent_frames_to_stop  = i_cfg_data;
                    CFG_ACTIVE_TO_START:   regs.active_frames_to_start = i_cfg_data;
                    CFG_PUBLISH_MIN_MS:    regs.publish_min_ms         = i_cfg_data;
                    CFG_FRAME_DURATION_MS: regs.frame_duration_ms      = i_cfg_data[DUR_W-1:0];
                    default: ;
                endcase
            end

            // sample transaction
            if (i_in_valid && i_in_ready) track_sample(i_in_item);
        end
        o_pending <= expected_frames.size();
    end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: frame voice activity capture
// Drives sample frames and register writes into the block under random
// valid and ready gaps. Traffic runs first under the reset settings, then a
// short directed sequence, a long capture that saturates the recording time,
// and random phases of loud and quiet frame runs plus free noise under
// extreme and random settings. The checker beside the block predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import fvac_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 11;
    localparam int TOTAL_SAMPLES  = 1900;
    localparam int SETTLE_CYCLES  = 4;
    localparam int STALL_LIMIT    = 2000;
    localparam int DIRECTED_LEN   = 20;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_item              in_item;
    logic                  out_valid;
    logic                  out_ready;
    t_out_item             out_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int         fail_count;
    int         pending;
    int         frames_checked;
    logic [4:0] actions_seen;

    // register values the stimulus shapes its frames around
    int   thr_now   = int'(RST_LEVEL_THRESH);
    int   stop_now  = int'(RST_SILENT_TO_STOP);
    int   start_now = int'(RST_ACTIVE_TO_START);
    int   sent_samples = 0;
    int   settings     = 1;
    int   quiet_cycles = 0;
    logic no_idle      = 1'b0;

    // three flush frames, then full-scale swings, threshold edges and a
    // publish limit that the recorded time meets without exceeding
    int dir_value [DIRECTED_LEN] = '{0, 0, 0, -32768, 32767, 32767, -32768, 500, -499,
                                     -500, 500, 0, -1, -32768, -31000, 100, 2000, 50,
                                     7, 7};
    bit dir_last  [DIRECTED_LEN] = '{1, 1, 1, 0, 1, 0, 1, 0, 1,
                                     0, 1, 1, 1, 0, 1, 0, 0, 1,
                                     1, 1};

    frame_voice_activity_capture uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    fvac_frame_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_in_item        (in_item),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_out_item       (out_item),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_frames_checked (frames_checked),
        .o_actions_seen   (actions_seen)
    );

    initial begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // Watchdog: too long without any transaction ends the run
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("no transaction for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result sink: random hold-off before taking each result
    initial begin : result_sink
        int hold;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 3);
            if (hold != 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // One sample transaction after a random gap; valid stays up afterwards
    task automatic push_sample(input logic [15:0] value, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{sample: value, frame_end: last};
        do @(posedge clk); while (!(in_valid && in_ready));
        sent_samples++;
    endtask

    // Frame whose peak-to-peak is exactly span (zero for one sample)
    task automatic push_frame(input int len, input int span);
        int lo;
        int at_lo;
        int at_hi;
        int value;
        lo    = int'($urandom_range(0, 65535 - span)) - 32768;
        at_lo = $urandom_range(0, len - 1);
        at_hi = $urandom_range(0, len - 1);
        if (len > 1 && at_hi == at_lo) at_hi = (at_lo + 1) % len;
        for (int i = 0; i < len; i++) begin
            if (i == at_lo) value = lo;
            else if (i == at_hi) value = lo + span;
            else value = lo + int'($urandom_range(0, span));
            push_sample(16'(value), i == len - 1);
        end
    endtask

    // Mostly short frames, now and then a longer one
    function automatic int pick_len();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
    endfunction

    // Peak-to-peak on the wanted side of the threshold, edges included
    function automatic int pick_span(input bit quiet);
        int s;
        if (quiet && thr_now > 0) begin
            case ($urandom_range(0, 3))
                0:       s = thr_now - 1;
                1:       s = 0;
                default: s = $urandom_range(0, thr_now - 1);
            endcase
        end else if (!quiet) begin
            case ($urandom_range(0, 3))
                0:       s = thr_now;
                1:       s = 65535;
                default: s = $urandom_range(thr_now, 65535);
            endcase
        end else begin
            s = $urandom_range(0, 65535);
        end
        return s;
    endfunction

    // Runs of loud frames then quiet frames sized to the run thresholds,
    // with an occasional burst of free noise
    task automatic run_episodes(input int count);
        int loud_frames;
        int quiet_frames;
        repeat (count) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 12)) push_sample(16'($urandom), $urandom_range(0, 3) == 0);
            end else begin
                loud_frames  = $urandom_range(1, (start_now > 6) ? 7 : start_now + 1);
                quiet_frames = $urandom_range(1, (stop_now > 6) ? 7 : stop_now + 1);
                repeat (loud_frames) push_frame(1 + pick_len(), pick_span(1'b0));
                repeat (quiet_frames) push_frame(pick_len(), pick_span(1'b1));
            end
        end
    endtask

    // Register write transaction; valid stays up for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        case (idx)
            CFG_LEVEL_THRESH:    thr_now   = int'(data);
            CFG_SILENT_TO_STOP:  stop_now  = int'(data);
            CFG_ACTIVE_TO_START: start_now = int'(data);
            default: ;
        endcase
    endtask

    // Stop sending, let every outstanding result arrive, then let the
    // pipeline settle so a register write cannot meet a frame in flight
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Stimulus
    initial begin : stimulus
        int                    goal;
        int                    sel;
        logic [15:0]           vol;
        logic [15:0]           stop_frames;
        logic [15:0]           start_frames;
        logic [15:0]           pub_ms;
        logic [15:0]           dur_ms;
        logic [CFG_IDX_W-1:0]  spare_idx;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings untouched
        run_episodes(6);
        wait_idle();

        // directed frames
        write_reg(CFG_LEVEL_THRESH, 16'd1000);
        write_reg(CFG_SILENT_TO_STOP, 16'd2);
        write_reg(CFG_ACTIVE_TO_START, 16'd2);
        write_reg(CFG_PUBLISH_MIN_MS, 16'd40);
        write_reg(CFG_FRAME_DURATION_MS, 16'd20);
        cfg_valid <= 1'b0;
        settings++;
        for (int i = 0; i < DIRECTED_LEN; i++) push_sample(16'(dir_value[i]), dir_last[i]);
        wait_idle();

        // long capture: recording time pins at its maximum, upper duration
        // bits are dropped, then a single quiet frame stops and publishes
        write_reg(CFG_SILENT_TO_STOP, 16'hFFFF);
        write_reg(CFG_ACTIVE_TO_START, 16'd0);
        write_reg(CFG_PUBLISH_MIN_MS, 16'hFFFE);
        write_reg(CFG_FRAME_DURATION_MS, 16'hFFFF);
        cfg_valid <= 1'b0;
        settings++;
        repeat (70) push_frame(1, 0);
        wait_idle();
        write_reg(CFG_SILENT_TO_STOP, 16'd1);
        cfg_valid <= 1'b0;
        settings++;
        push_frame(1, 0);
        push_frame(1, 0);
        wait_idle();

        // random phases: extreme settings first, then random ones
        goal = TOTAL_SAMPLES;
        for (int phase = 0; sent_samples < goal; phase++) begin
            sel = (phase < 5) ? phase : $urandom_range(5, 9);
            case (sel)
                0: begin
                    vol = 16'd0;      stop_frames = 16'd0;      start_frames = 16'd1;
                    pub_ms = 16'd0;   dur_ms = 16'd1;
                end
                1: begin
                    vol = 16'hFFFF;   stop_frames = 16'd1;      start_frames = 16'd0;
                    pub_ms = 16'hFFFF; dur_ms = 16'd1000;
                end
                2: begin
                    vol = 16'd1;      stop_frames = 16'hFFFF;   start_frames = 16'hFFFF;
                    pub_ms = 16'd0;   dur_ms = 16'd0;
                end
                3: begin
                    vol = 16'($urandom); stop_frames = 16'd2;   start_frames = 16'd3;
                    pub_ms = 16'($urandom); dur_ms = 16'($urandom);
                end
                4: begin
                    vol = 16'h5555;   stop_frames = 16'd3;      start_frames = 16'd2;
                    pub_ms = 16'hAAAA; dur_ms = 16'hFDFF;
                end
                default: begin
                    vol = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(200, 4000));
                    stop_frames  = 16'($urandom_range(1, 6));
                    start_frames = 16'($urandom_range(1, 4));
                    pub_ms       = 16'($urandom_range(0, 150));
                    dur_ms       = 16'($urandom_range(1, 60));
                end
            endcase
            write_reg(CFG_LEVEL_THRESH, vol);
            write_reg(CFG_SILENT_TO_STOP, stop_frames);
            write_reg(CFG_ACTIVE_TO_START, start_frames);
            write_reg(CFG_PUBLISH_MIN_MS, pub_ms);
            write_reg(CFG_FRAME_DURATION_MS, dur_ms);
            // writes past the register list must change nothing
            if ($urandom_range(0, 2) == 0) begin
                spare_idx = CFG_IDX_W'(CFG_FRAME_DURATION_MS + $urandom_range(1, 3));
                write_reg(spare_idx, 16'($urandom));
            end
            cfg_valid <= 1'b0;
            settings++;
            no_idle <= ($urandom_range(0, 3) == 0);
            run_episodes(10);
            wait_idle();
        end

        $display("Run covered %0d samples under %0d register settings, %0d frame results checked",
                 sent_samples, settings, frames_checked);
        $display("Capture actions seen, publish/discard/record/start/drop: %b", actions_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
design/fvac_pkg.sv
design/fvac_cfg_regs.sv
design/fvac_minmax.sv
design/fvac_decide.sv
design/frame_voice_activity_capture.sv
design/fvac_checker.sv
verif/fvac_frame_checker.sv
verif/testbench.sv
